>>> rtl/gbts_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package gbts_pkg;

	localparam int OP_W   = 2;
	localparam int POS_W  = 11;
	localparam int CHAR_W = 8;
	localparam int STAT_W = 2;
	localparam int IN_TDATA_W  = 24;
	localparam int OUT_TDATA_W = 24;

	localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
	localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
	localparam logic [OP_W-1:0] OP_READ   = 2'd2;

	localparam logic [STAT_W-1:0] ST_DONE    = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL    = 2'd1;
	localparam logic [STAT_W-1:0] ST_BEYOND  = 2'd2;
	localparam logic [STAT_W-1:0] ST_NOTHING = 2'd3;

	typedef struct packed {
		logic              latch;
		logic              rd_issue;
		logic              step;
		logic              finish;
		logic              load;
		logic [STAT_W-1:0] status;
		logic              use_rd;
	} gbts_cmd_t;

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic            pos_gt_len;
		logic            pos_ge_len;
		logic            pos_zero;
		logic            full;
		logic            at_pos;
		logic            pend;
		logic            out_free;
	} gbts_st_t;

endpackage
`default_nettype wire

>>> rtl/gap_buffer_text_store.sv
`timescale 1ns / 1ps
`default_nettype none
// Gap buffer text store of CAPACITY bytes. Each transaction on the input stream is one
// operation (insert, backspace-style remove or read at a logical position) and yields
// exactly one result transaction. Items are handled one at a time: an edit first moves
// the gap to the position, copying one character per cycle through the store, which
// reads the next byte in the same cycle as it writes the previous one. A finished result
// waits in the output register while the next item is accepted.
module gap_buffer_text_store #(
	parameter int CAPACITY = 1024
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                s_axis_tvalid,
	output logic                                     s_axis_tready,
	// opcode [1:0], position [12:2], char_in [20:13], zero [23:21]
	input  wire logic [gbts_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
	output logic                                     m_axis_tvalid,
	input  wire logic                                m_axis_tready,
	// status [1:0], char_out [9:2], text_length [20:10], zero [23:21]
	output logic [gbts_pkg::OUT_TDATA_W-1:0]         m_axis_tdata
);
	import gbts_pkg::*;

	gbts_cmd_t cmd;
	gbts_st_t  st;

	gbts_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.st       (st),
		.cmd      (cmd)
	);

	gbts_dp #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.st        (st),
		.in_data   (s_axis_tdata),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata)
	);

`ifndef SYNTH
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
		else $error("second transaction accepted while one is in progress");

	a_step_only_off_target: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> !st.at_pos)
		else $error("gap moved past the target position");

	a_finish_after_drain: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> !st.pend)
		else $error("edit completed with a gap copy still pending");
`endif

endmodule
`default_nettype wire

>>> rtl/gbts_dp.sv
`timescale 1ns / 1ps
`default_nettype none
module gbts_dp #(
	parameter int CAPACITY = 1024
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire gbts_pkg::gbts_cmd_t                cmd,
	output gbts_pkg::gbts_st_t                      st,
	input  wire logic [gbts_pkg::IN_TDATA_W-1:0]    in_data,
	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output logic [gbts_pkg::OUT_TDATA_W-1:0]        out_data
);
	import gbts_pkg::*;

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int WW = (CW > POS_W) ? CW : POS_W;

	logic [CHAR_W-1:0] mem [CAPACITY];

	logic [OP_W-1:0]   op_q;
	logic [POS_W-1:0]  pos_q;
	logic [CHAR_W-1:0] ch_q;
	logic [CW-1:0]     gs_q;
	logic [CW-1:0]     ge_q;
	logic [CHAR_W-1:0] rdata_q;
	logic              pend_q;
	logic [AW-1:0]     pend_addr_q;
	logic              out_valid_q;
	logic [STAT_W-1:0] status_q;
	logic [CHAR_W-1:0] char_q;
	logic [POS_W-1:0]  len_q;

	logic [CW-1:0] gap;
	logic [CW-1:0] len;
	logic [CW-1:0] gs_m1;
	logic [CW-1:0] ge_m1;
	logic [WW-1:0] len_w;
	logic [WW-1:0] pos_w;
	logic [WW-1:0] gs_w;
	logic [WW-1:0] rd_idx;
	logic          go_left;
	logic          rd_en;
	logic [AW-1:0] ra;
	logic          we;
	logic [AW-1:0] wa;
	logic [CHAR_W-1:0] wd;

	assign gap    = ge_q - gs_q;
	assign len    = CW'(CAPACITY) - gap;
	assign gs_m1  = gs_q - 1'b1;
	assign ge_m1  = ge_q - 1'b1;
	assign len_w  = WW'(len);
	assign pos_w  = WW'(pos_q);
	assign gs_w   = WW'(gs_q);
	assign rd_idx = (pos_w < gs_w) ? pos_w : (pos_w + WW'(gap));
	assign go_left = gs_w > pos_w;

	assign st.op         = op_q;
	assign st.pos_gt_len = pos_w > len_w;
	assign st.pos_ge_len = pos_w >= len_w;
	assign st.pos_zero   = pos_q == '0;
	assign st.full       = len == CW'(CAPACITY);
	assign st.at_pos     = gs_w == pos_w;
	assign st.pend       = pend_q;
	assign st.out_free   = !out_valid_q || out_ready;

	assign rd_en = cmd.step || cmd.rd_issue;

	always_comb begin
		if (cmd.rd_issue) begin
			ra = rd_idx[AW-1:0];
		end else if (go_left) begin
			ra = gs_m1[AW-1:0];
		end else begin
			ra = ge_q[AW-1:0];
		end
	end

	assign we = pend_q || (cmd.finish && (op_q == OP_INSERT));
	assign wa = pend_q ? pend_addr_q : gs_q[AW-1:0];
	assign wd = pend_q ? rdata_q : ch_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		if (rd_en) begin
			rdata_q <= mem[ra];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			op_q  <= in_data[OP_W-1:0];
			pos_q <= in_data[OP_W+POS_W-1:OP_W];
			ch_q  <= in_data[OP_W+POS_W+CHAR_W-1:OP_W+POS_W];
		end
		if (cmd.step) begin
			pend_addr_q <= go_left ? ge_m1[AW-1:0] : gs_q[AW-1:0];
		end
		if (cmd.load) begin
			status_q <= cmd.status;
			char_q   <= cmd.use_rd ? rdata_q : '0;
			len_q    <= len_w[POS_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gs_q        <= '0;
			ge_q        <= CW'(CAPACITY);
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			pend_q <= cmd.step;
			if (cmd.step) begin
				if (go_left) begin
					gs_q <= gs_m1;
					ge_q <= ge_m1;
				end else begin
					gs_q <= gs_q + 1'b1;
					ge_q <= ge_q + 1'b1;
				end
			end else if (cmd.finish) begin
				if (op_q == OP_INSERT) begin
					gs_q <= gs_q + 1'b1;
				end else begin
					gs_q <= gs_m1;
				end
			end
			if (cmd.load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = {(OUT_TDATA_W - STAT_W - CHAR_W - POS_W)'(0), len_q, char_q, status_q};

endmodule
`default_nettype wire

>>> rtl/gbts_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module gbts_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire gbts_pkg::gbts_st_t  st,
	output gbts_pkg::gbts_cmd_t      cmd
);
	import gbts_pkg::*;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_DECIDE = 3'd1;
	localparam logic [2:0] S_RDWAIT = 3'd2;
	localparam logic [2:0] S_MOVE   = 3'd3;
	localparam logic [2:0] S_RESULT = 3'd4;

	logic [2:0]        state_q;
	logic [2:0]        state_d;
	logic [STAT_W-1:0] status_q;
	logic [STAT_W-1:0] status_d;
	logic              use_rd_q;
	logic              use_rd_d;

	assign in_ready = state_q == S_IDLE;

	always_comb begin
		state_d  = state_q;
		status_d = status_q;
		use_rd_d = use_rd_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_DECIDE;
				end
			end
			S_DECIDE: begin
				status_d = ST_DONE;
				use_rd_d = 1'b0;
				state_d  = S_RESULT;
				unique case (st.op)
					OP_INSERT: begin
						if (st.pos_gt_len) begin
							status_d = ST_BEYOND;
						end else if (st.full) begin
							status_d = ST_FULL;
						end else begin
							state_d = S_MOVE;
						end
					end
					OP_REMOVE: begin
						if (st.pos_gt_len) begin
							status_d = ST_BEYOND;
						end else if (st.pos_zero) begin
							status_d = ST_NOTHING;
						end else begin
							state_d = S_MOVE;
						end
					end
					OP_READ: begin
						if (st.pos_ge_len) begin
							status_d = ST_BEYOND;
						end else begin
							use_rd_d = 1'b1;
							state_d  = S_RDWAIT;
						end
					end
					default: begin
						status_d = ST_DONE;
					end
				endcase
			end
			S_RDWAIT: begin
				state_d = S_RESULT;
			end
			S_MOVE: begin
				if (st.at_pos && !st.pend) begin
					state_d = S_RESULT;
				end
			end
			S_RESULT: begin
				if (st.out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			status_q <= ST_DONE;
			use_rd_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			status_q <= status_d;
			use_rd_q <= use_rd_d;
		end
	end

	assign cmd.latch    = in_ready && in_valid;
	assign cmd.rd_issue = (state_q == S_DECIDE) && (st.op == OP_READ) && !st.pos_ge_len;
	assign cmd.step     = (state_q == S_MOVE) && !st.at_pos;
	assign cmd.finish   = (state_q == S_MOVE) && st.at_pos && !st.pend;
	assign cmd.load     = (state_q == S_RESULT) && st.out_free;
	assign cmd.status   = status_q;
	assign cmd.use_rd   = use_rd_q;

endmodule
`default_nettype wire
